>>> hdl/dbp_pkg.sv
// shared types and constants for the depth pixel back-projection block
package dbp_pkg;

    localparam int COORD_BITS = 12;
    localparam int COORD_MASK_INT = (1 << COORD_BITS) - 1;
    localparam logic [11:0] COORD_MASK = 12'(COORD_MASK_INT);

    localparam int WORD_W   = 48;
    localparam int DIV_W    = 16;
    localparam int Z_STEPS  = 32;
    localparam int XY_STEPS = 48;

    localparam logic [2:0] REG_FOCAL_X     = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y     = 3'd1;
    localparam logic [2:0] REG_CENTER_X    = 3'd2;
    localparam logic [2:0] REG_CENTER_Y    = 3'd3;
    localparam logic [2:0] REG_DEPTH_SCALE = 3'd4;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [15:0] raw_depth;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] point_x;
        logic signed [47:0] point_y;
        logic [31:0]        point_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
    } out_item_t;

    // data that rides along the chain untouched by the divider lanes
    typedef struct packed {
        logic [15:0] mag_x;
        logic        neg_x;
        logic [15:0] mag_y;
        logic        neg_y;
        logic [31:0] z;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } side_t;

    typedef struct packed {
        logic              valid;
        logic [DIV_W-1:0]  rem_a;
        logic [WORD_W-1:0] word_a;
        logic [DIV_W-1:0]  rem_b;
        logic [WORD_W-1:0] word_b;
        side_t             side;
    } cell_t;

endpackage

>>> hdl/depth_pixel_backprojection.sv
// top level: pinhole back-projection of depth pixels into colored points
// stages: 32 z division cells, one multiply stage, 48 x/y division cells and one
// output register between input accept and m_valid
// throughput: one item per cycle; the whole chain advances when the output
// register is empty or taken, so a stalled output holds every stage
// reset: synchronous active-low aresetn clears all valid bits and loads the
// intrinsics registers with their defaults; pixels with zero depth leave no item
module depth_pixel_backprojection
    import dbp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // intrinsics registers
    logic [15:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg, depth_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg     <= 16'd8192;
            focal_y_reg     <= 16'd8192;
            center_x_reg    <= 16'd5120;
            center_y_reg    <= 16'd3840;
            depth_scale_reg <= 16'd1000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FOCAL_X:     focal_x_reg     <= cfg_data;
                REG_FOCAL_Y:     focal_y_reg     <= cfg_data;
                REG_CENTER_X:    center_x_reg    <= cfg_data;
                REG_CENTER_Y:    center_y_reg    <= cfg_data;
                REG_DEPTH_SCALE: depth_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole chain moves together whenever the output slot can take an item
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // entry: pixel offsets from the principal point, sign and magnitude
    logic [15:0] p16_x, p16_y;
    cell_t       z_chain [0:Z_STEPS];

    always_comb begin
        p16_x = {s_item.column & COORD_MASK, 4'b0000};
        p16_y = {s_item.row & COORD_MASK, 4'b0000};
        z_chain[0]            = '0;
        z_chain[0].valid      = s_valid && (s_item.raw_depth != 16'd0);
        // dividend raw_depth << 16 sits at the top of the shifting word
        z_chain[0].word_a     = {s_item.raw_depth, 32'd0};
        z_chain[0].side.neg_x = center_x_reg > p16_x;
        z_chain[0].side.mag_x = (center_x_reg > p16_x) ? center_x_reg - p16_x
                                                        : p16_x - center_x_reg;
        z_chain[0].side.neg_y = center_y_reg > p16_y;
        z_chain[0].side.mag_y = (center_y_reg > p16_y) ? center_y_reg - p16_y
                                                        : p16_y - center_y_reg;
        z_chain[0].side.red   = s_item.red_in;
        z_chain[0].side.green = s_item.green_in;
        z_chain[0].side.blue  = s_item.blue_in;
    end

    // z = (raw_depth << 16) / depth_scale, one quotient bit per cell
    // a zero scale makes every trial succeed, so z saturates to all ones
    for (genvar i = 0; i < Z_STEPS; i++) begin : g_z
        dbp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .div_a    (depth_scale_reg),
            .div_b    (16'd1),
            .cell_in  (z_chain[i]),
            .cell_out (z_chain[i+1])
        );
    end

    // multiply stage: offset magnitude times z
    logic [31:0] z_val;
    logic        mul_valid_reg;
    logic [47:0] prod_x_reg, prod_y_reg;
    side_t       mul_side_reg;
    side_t       mul_side_next;

    assign z_val = z_chain[Z_STEPS].word_a[31:0];

    always_comb begin
        mul_side_next   = z_chain[Z_STEPS].side;
        mul_side_next.z = z_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (adv) begin
            mul_valid_reg <= z_chain[Z_STEPS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_x_reg   <= 48'(z_chain[Z_STEPS].side.mag_x) * 48'(z_val);
            prod_y_reg   <= 48'(z_chain[Z_STEPS].side.mag_y) * 48'(z_val);
            mul_side_reg <= mul_side_next;
        end
    end

    // x and y divisions by the focal lengths run side by side
    cell_t xy_chain [0:XY_STEPS];

    always_comb begin
        xy_chain[0]        = '0;
        xy_chain[0].valid  = mul_valid_reg;
        xy_chain[0].word_a = prod_x_reg;
        xy_chain[0].word_b = prod_y_reg;
        xy_chain[0].side   = mul_side_reg;
    end

    for (genvar j = 0; j < XY_STEPS; j++) begin : g_xy
        dbp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .div_a    (focal_x_reg),
            .div_b    (focal_y_reg),
            .cell_in  (xy_chain[j]),
            .cell_out (xy_chain[j+1])
        );
    end

    // sign, saturation to 48 bits, zero focal length gives zero
    function automatic logic [47:0] apply_sign(input logic [47:0] q, input logic neg,
                                               input logic focal_zero);
        logic [47:0] res;
        begin
            if (focal_zero) begin
                res = '0;
            end else if (neg) begin
                res = (q > {1'b1, 47'd0}) ? {1'b1, 47'd0} : (48'd0 - q);
            end else begin
                res = q[47] ? {1'b0, {47{1'b1}}} : q;
            end
            return res;
        end
    endfunction

    cell_t     xy_last;
    logic      m_valid_reg;
    out_item_t m_item_reg;

    assign xy_last = xy_chain[XY_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= xy_last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_item_reg.point_x   <= apply_sign(xy_last.word_a, xy_last.side.neg_x,
                                               focal_x_reg == 16'd0);
            m_item_reg.point_y   <= apply_sign(xy_last.word_b, xy_last.side.neg_y,
                                               focal_y_reg == 16'd0);
            m_item_reg.point_z   <= xy_last.side.z;
            m_item_reg.red_out   <= xy_last.side.red;
            m_item_reg.green_out <= xy_last.side.green;
            m_item_reg.blue_out  <= xy_last.side.blue;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // zero-depth pixels never enter the chain
    a_zero_depth_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.raw_depth == 16'd0) |=> !z_chain[1].valid)
        else $error("zero depth pixel entered the chain");

    // zero scale saturates z
    a_zero_scale_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && depth_scale_reg == 16'd0) |-> (m_item.point_z == 32'hFFFF_FFFF))
        else $error("z not saturated for zero depth scale");

    // zero focal length zeroes the coordinate
    a_zero_focal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && focal_x_reg == 16'd0) |-> (m_item.point_x == 48'sd0))
        else $error("x not zero for zero focal length");

    // a stalled output freezes the multiply stage
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(mul_valid_reg))
        else $error("chain moved during output stall");

endmodule

>>> hdl/dbp_cell.sv
// one restoring division step on two lanes, registered
module dbp_cell
    import dbp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [DIV_W-1:0] div_a,
    input  logic [DIV_W-1:0] div_b,
    input  cell_t            cell_in,
    output cell_t            cell_out
);

    logic [DIV_W:0] trial_a, trial_b, diff_a, diff_b;
    logic           ge_a, ge_b;
    cell_t          cell_next;
    logic           valid_reg;
    cell_t          data_reg;

    always_comb begin
        trial_a = {cell_in.rem_a, cell_in.word_a[WORD_W-1]};
        trial_b = {cell_in.rem_b, cell_in.word_b[WORD_W-1]};
        diff_a  = trial_a - {1'b0, div_a};
        diff_b  = trial_b - {1'b0, div_b};
        ge_a    = trial_a >= {1'b0, div_a};
        ge_b    = trial_b >= {1'b0, div_b};
        cell_next        = cell_in;
        cell_next.rem_a  = ge_a ? diff_a[DIV_W-1:0] : trial_a[DIV_W-1:0];
        cell_next.rem_b  = ge_b ? diff_b[DIV_W-1:0] : trial_b[DIV_W-1:0];
        cell_next.word_a = {cell_in.word_a[WORD_W-2:0], ge_a};
        cell_next.word_b = {cell_in.word_b[WORD_W-2:0], ge_b};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= cell_next;
        end
    end

    always_comb begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

>>> tb/testbench.sv
// testbench for the depth pixel back-projection block
module testbench;
    import dbp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 82;
    localparam int STALL_LIMIT = 20000;
    localparam int NUM_RANDOM  = 450;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    depth_pixel_backprojection dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor's own copy of the intrinsics
    logic [15:0] cam_fx, cam_fy, cam_cx, cam_cy, cam_scale;

    out_item_t expected_points[$];
    int        error_count;
    int        idle_cycles;
    bit        rx_stall_on;

    // directed stimulus: pixel plus a hand-computed point where it is obvious
    typedef struct {
        in_item_t  pix;
        bit        typed;
        out_item_t point;
    } pixel_row_t;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // one axis of the pinhole projection, saturated to 48 signed bits
    function automatic logic [47:0] project_coord(input logic [11:0] pix,
            input logic [15:0] center, input logic [15:0] focal, input logic [31:0] z);
        logic [63:0]  p16;
        logic [63:0]  mag;
        logic [127:0] quot;
        bit           neg;
        p16 = 64'(pix & COORD_MASK) << 4;
        neg = 64'(center) > p16;
        mag = neg ? 64'(center) - p16 : p16 - 64'(center);
        if (focal == 16'd0) return 48'd0;
        quot = (128'(mag) * 128'(z)) / 128'(focal);
        if (neg) begin
            if (quot > 128'(64'd1 << 47)) quot = 128'(64'd1 << 47);
            return 48'(-quot);
        end
        if (quot > 128'((64'd1 << 47) - 1)) quot = 128'((64'd1 << 47) - 1);
        return 48'(quot);
    endfunction

    function automatic out_item_t backproject(input in_item_t pix);
        out_item_t pt;
        logic [31:0] z;
        z = (cam_scale == 16'd0) ? 32'hFFFF_FFFF
                                 : 32'((48'(pix.raw_depth) << 16) / cam_scale);
        pt.point_x   = project_coord(pix.column, cam_cx, cam_fx, z);
        pt.point_y   = project_coord(pix.row, cam_cy, cam_fy, z);
        pt.point_z   = z;
        pt.red_out   = pix.red_in;
        pt.green_out = pix.green_in;
        pt.blue_out  = pix.blue_in;
        return pt;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FOCAL_X:     cam_fx    = value;
            REG_FOCAL_Y:     cam_fy    = value;
            REG_CENTER_X:    cam_cx    = value;
            REG_CENTER_Y:    cam_cy    = value;
            REG_DEPTH_SCALE: cam_scale = value;
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [15:0] fx, input logic [15:0] fy,
            input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] scale);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_DEPTH_SCALE, scale);
    endtask

    // hand one pixel over and, for nonzero depth, queue its predicted point;
    // valid stays up between back-to-back items, dropped only for a gap or a drain
    task automatic send_pixel(input in_item_t pix, input bit typed, input out_item_t pt);
        s_valid <= 1'b1;
        s_item  <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (pix.raw_depth != 16'd0)
            expected_points.insert(expected_points.size(), typed ? pt : backproject(pix));
    endtask

    task automatic gap(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // let the pipeline drain so registers can change safely
    task automatic drain;
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic in_item_t random_pixel(input bit allow_zero);
        in_item_t pix;
        pix.column    = 12'($urandom);
        pix.row       = 12'($urandom);
        pix.raw_depth = 16'($urandom);
        case ($urandom_range(0, 7))
            0: pix.raw_depth = allow_zero ? 16'd0 : 16'd1;
            1: pix.raw_depth = 16'hFFFF;
            2: pix.raw_depth = 16'($urandom_range(1, 4000));
            default: ;
        endcase
        if (pix.raw_depth == 16'd0 && !allow_zero) pix.raw_depth = 16'd1;
        pix.blue_in  = 8'($urandom);
        pix.green_in = 8'($urandom);
        pix.red_in   = 8'($urandom);
        return pix;
    endfunction

    // receiver: stall pattern alternates between busy stretches and free runs
    initial begin
        int phase_len;
        m_ready     = 1'b0;
        rx_stall_on = 1'b0;
        phase_len   = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (phase_len == 0) begin
                rx_stall_on = !rx_stall_on;
                phase_len   = $urandom_range(5, 60);
            end
            phase_len--;
            m_ready <= rx_stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
            @(posedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                $display("unexpected point at %0t", $realtime);
                error_count++;
            end else begin
                out_item_t want;
                want = expected_points.pop_front();
                if (m_item.point_x !== want.point_x)
                    report_mismatch("point_x", 64'(m_item.point_x), 64'(want.point_x));
                if (m_item.point_y !== want.point_y)
                    report_mismatch("point_y", 64'(m_item.point_y), 64'(want.point_y));
                if (m_item.point_z !== want.point_z)
                    report_mismatch("point_z", 64'(m_item.point_z), 64'(want.point_z));
                if (m_item.red_out !== want.red_out)
                    report_mismatch("red_out", 64'(m_item.red_out), 64'(want.red_out));
                if (m_item.green_out !== want.green_out)
                    report_mismatch("green_out", 64'(m_item.green_out), 64'(want.green_out));
                if (m_item.blue_out !== want.blue_out)
                    report_mismatch("blue_out", 64'(m_item.blue_out), 64'(want.blue_out));
            end
        end
    end

    // watchdog: cycles without any handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        pixel_row_t directed[$];
        pixel_row_t r;
        out_item_t  none;
        int         burst;
        int         sent;
        logic [15:0] sets[6][5];

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_FOCAL_X;
        cfg_data    = '0;
        error_count = 0;
        none        = '0;
        cam_fx = 16'd8192; cam_fy = 16'd8192;
        cam_cx = 16'd5120; cam_cy = 16'd3840; cam_scale = 16'd1000;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset intrinsics: pixel at the principal point, depth 1000 gives 1 m
        r.pix = '{column: 12'd320, row: 12'd240, raw_depth: 16'd1000,
                  blue_in: 8'h11, green_in: 8'h22, red_in: 8'h33};
        r.typed = 1'b1;
        r.point = '{point_x: 48'sd0, point_y: 48'sd0, point_z: 32'h0001_0000,
                    red_out: 8'h33, green_out: 8'h22, blue_out: 8'h11};
        directed.insert(directed.size(), r);
        // zero depth leaves no point
        r.pix = '{column: 12'd5, row: 12'd7, raw_depth: 16'd0,
                  blue_in: 8'hFF, green_in: 8'hFF, red_in: 8'hFF};
        r.typed = 1'b1; r.point = none;
        directed.insert(directed.size(), r);
        // field extremes, predictor checked
        r.typed = 1'b0;
        r.pix = '{column: 12'd0, row: 12'd0, raw_depth: 16'd1,
                  blue_in: 8'h00, green_in: 8'h00, red_in: 8'h00};
        directed.insert(directed.size(), r);
        r.pix = '{column: 12'hFFF, row: 12'hFFF, raw_depth: 16'hFFFF,
                  blue_in: 8'hFF, green_in: 8'hFF, red_in: 8'hFF};
        directed.insert(directed.size(), r);
        r.pix = '{column: 12'hFFF, row: 12'd0, raw_depth: 16'hFFFF,
                  blue_in: 8'hA5, green_in: 8'h5A, red_in: 8'hC3};
        directed.insert(directed.size(), r);
        r.pix = '{column: 12'd0, row: 12'hFFF, raw_depth: 16'h8000,
                  blue_in: 8'h3C, green_in: 8'h96, red_in: 8'h69};
        directed.insert(directed.size(), r);
        foreach (directed[i]) send_pixel(directed[i].pix, directed[i].typed,
                                         directed[i].point);
        drain();

        // zero scale saturates z; zero focal zeroes the coordinates
        set_camera(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        r.pix = '{column: 12'd100, row: 12'd200, raw_depth: 16'd7,
                  blue_in: 8'h01, green_in: 8'h02, red_in: 8'h03};
        r.point = '{point_x: 48'sd0, point_y: 48'sd0, point_z: 32'hFFFF_FFFF,
                    red_out: 8'h03, green_out: 8'h02, blue_out: 8'h01};
        send_pixel(r.pix, 1'b1, r.point);
        drain();
        // tiny focal with huge z and offset: the negative y coordinate saturates
        write_reg(REG_FOCAL_X, 16'd16);
        write_reg(REG_FOCAL_Y, 16'd1);
        write_reg(REG_CENTER_Y, 16'hFFFF);
        drain();
        send_pixel('{column: 12'hFFF, row: 12'd0, raw_depth: 16'hFFFF,
                     blue_in: 8'h0F, green_in: 8'hF0, red_in: 8'h55}, 1'b0, none);
        send_pixel('{column: 12'd0, row: 12'hFFF, raw_depth: 16'd1,
                     blue_in: 8'h80, green_in: 8'h40, red_in: 8'h20}, 1'b0, none);
        drain();
        // unknown register index is ignored by both sides
        write_reg(3'd5, 16'h1234);
        write_reg(3'd7, 16'hFFFF);

        sets[0] = '{16'd8192, 16'd8192, 16'd5120, 16'd3840, 16'd1000};
        sets[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        sets[2] = '{16'd16, 16'd16, 16'd0, 16'd0, 16'd1};
        sets[3] = '{16'd9000, 16'd7000, 16'd32768, 16'd20000, 16'd5000};
        sets[4] = '{16'd0, 16'd300, 16'd65535, 16'd0, 16'd0};
        sets[5] = '{16'($urandom_range(16, 65535)), 16'($urandom_range(16, 65535)),
                    16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535))};

        // random phases: bursts of pixels with random gaps, mostly valid depth
        for (int s = 0; s < 6; s++) begin
            drain();
            set_camera(sets[s][0], sets[s][1], sets[s][2], sets[s][3], sets[s][4]);
            sent = 0;
            while (sent < NUM_RANDOM / 6) begin
                burst = $urandom_range(1, 30);
                for (int k = 0; k < burst && sent < NUM_RANDOM / 6; k++) begin
                    send_pixel(random_pixel($urandom_range(0, 9) == 0), 1'b0, none);
                    sent++;
                end
                if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 12));
            end
        end
        drain();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/dbp_pkg.sv
hdl/dbp_cell.sv
hdl/depth_pixel_backprojection.sv
tb/testbench.sv
